>>> hdl/xdiv_pkg.sv
// Package for the DIV/IDIV divider: flag bit positions, chain state type,
// result type and the SUB flag function. No dependencies.
`default_nettype none
package xdiv_pkg;

  localparam int NumCells = 16;
  localparam int ByteCells = 8;

  localparam int FlCf = 0;
  localparam int FlPf = 2;
  localparam int FlAf = 4;
  localparam int FlZf = 6;
  localparam int FlSf = 7;
  localparam int FlOf = 11;

  typedef struct packed {
    logic        word;
    logic        sgn;
    logic        neg_div;
    logic        neg_q;
    logic        rep;
    logic        fault;
    logic        carry;
    logic [15:0] a;
    logic [15:0] c;
    logic [15:0] b;
    logic [15:0] flags;
  } div_state_t;

  typedef struct packed {
    logic        divide_fault;
    logic [15:0] quotient_out;
    logic [15:0] remainder_out;
    logic [15:0] flags_after;
  } div_res_t;

  typedef struct packed {
    logic [15:0] flags;
    logic [15:0] diff;
  } sub_res_t;

  function automatic logic [15:0] width_mask(input logic word);
    return word ? 16'hFFFF : 16'h00FF;
  endfunction

  function automatic logic top_bit(input logic [15:0] v, input logic word);
    return word ? v[15] : v[7];
  endfunction

  function automatic sub_res_t sub_flags(input logic [15:0] a, input logic [15:0] b,
                                         input logic word, input logic [15:0] fl);
    sub_res_t    res;
    logic [15:0] r;
    logic [15:0] f;
    r = (a - b) & width_mask(word);
    f = fl;
    f[FlCf] = (a < b);
    f[FlPf] = ~^r[7:0];
    f[FlAf] = a[4] ^ b[4] ^ r[4];
    f[FlZf] = (r == 16'h0000);
    f[FlSf] = top_bit(r, word);
    f[FlOf] = top_bit((a ^ b) & (a ^ r), word);
    res.flags = f;
    res.diff = r;
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/xdiv_if.sv
// Valid/ready channel interfaces for divide requests and divide results.
// Depends on nothing.
`default_nettype none
interface xdiv_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        word_width;
  logic [15:0] dividend_high;
  logic [15:0] dividend_low;
  logic [15:0] divisor_value;
  logic [15:0] flags_before;
  logic        rep_prefix;

  modport source(output valid, output operation, output word_width, output dividend_high,
                 output dividend_low, output divisor_value, output flags_before,
                 output rep_prefix, input ready);
  modport sink(input valid, input operation, input word_width, input dividend_high,
               input dividend_low, input divisor_value, input flags_before,
               input rep_prefix, output ready);
endinterface

interface xdiv_out_if;
  logic        valid;
  logic        ready;
  logic        divide_fault;
  logic [15:0] quotient_out;
  logic [15:0] remainder_out;
  logic [15:0] flags_after;

  modport source(output valid, output divide_fault, output quotient_out,
                 output remainder_out, output flags_after, input ready);
  modport sink(input valid, input divide_fault, input quotient_out,
               input remainder_out, input flags_after, output ready);
endinterface
`default_nettype wire

>>> hdl/xdiv_prep.sv
// Operand stage: width masking, IDIV absolute values and the initial
// overflow trial subtraction. Depends on xdiv_pkg.
`default_nettype none
module xdiv_prep import xdiv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic        operation_i,
  input  wire logic        word_width_i,
  input  wire logic [15:0] dividend_high_i,
  input  wire logic [15:0] dividend_low_i,
  input  wire logic [15:0] divisor_value_i,
  input  wire logic [15:0] flags_before_i,
  input  wire logic        rep_prefix_i,
  output logic             valid_o,
  output div_state_t       state_o
);

  logic        valid_q;
  div_state_t  state_d, state_q;
  logic [15:0] mask, hi, lo, dv;
  sub_res_t    sr;

  always_comb begin
    mask = width_mask(word_width_i);
    hi = dividend_high_i & mask;
    lo = dividend_low_i & mask;
    dv = divisor_value_i & mask;
    state_d.neg_div = 1'b0;
    state_d.neg_q = 1'b0;
    if (operation_i) begin
      if (top_bit(hi, word_width_i)) begin
        state_d.neg_div = 1'b1;
        state_d.neg_q = 1'b1;
        hi = (lo != 16'h0000) ? (~hi & mask) : ((16'h0000 - hi) & mask);
        lo = (16'h0000 - lo) & mask;
      end
      if (top_bit(dv, word_width_i)) begin
        state_d.neg_q = ~state_d.neg_q;
        dv = (16'h0000 - dv) & mask;
      end
    end
    sr = sub_flags(hi, dv, word_width_i, flags_before_i);
    state_d.word = word_width_i;
    state_d.sgn = operation_i;
    state_d.rep = rep_prefix_i;
    state_d.carry = sr.flags[FlCf];
    state_d.fault = ~sr.flags[FlCf];
    state_d.a = hi;
    state_d.c = lo;
    state_d.b = dv;
    state_d.flags = sr.flags;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

>>> hdl/xdiv_cell.sv
// One cell of the divide chain: a rotate-through-carry step and a trial
// subtraction, registered. Depends on xdiv_pkg.
`default_nettype none
module xdiv_cell import xdiv_pkg::*; #(
  parameter int Step = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire div_state_t  state_i,
  output logic             valid_o,
  output div_state_t       state_o
);

  logic       valid_q;
  div_state_t state_d, state_q;
  logic       active, c_out, a_out;
  logic [15:0] mask, a_rot;
  sub_res_t   sr;

  always_comb begin
    state_d = state_i;
    mask = width_mask(state_i.word);
    active = !state_i.fault && (state_i.word || (Step < ByteCells));
    c_out = top_bit(state_i.c, state_i.word);
    a_out = top_bit(state_i.a, state_i.word);
    a_rot = {state_i.a[14:0], c_out} & mask;
    sr = sub_flags(a_rot, state_i.b, state_i.word, state_i.flags);
    if (active) begin
      state_d.c = {state_i.c[14:0], state_i.carry} & mask;
      if (a_out) begin
        state_d.carry = 1'b0;
        state_d.a = (a_rot - state_i.b) & mask;
      end else begin
        state_d.flags = sr.flags;
        state_d.carry = sr.flags[FlCf];
        state_d.a = sr.flags[FlCf] ? a_rot : sr.diff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

>>> hdl/xdiv_final.sv
// Result stage: final quotient rotate and carry peek, sign restore, range
// fault and flag cleanup, held in the output register. Depends on xdiv_pkg.
`default_nettype none
module xdiv_final import xdiv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire div_state_t  state_i,
  output logic             valid_o,
  output div_res_t         res_o
);

  logic        valid_q;
  div_res_t    res_d, res_q;
  logic [15:0] mask, qcomp, fl;
  logic        peek, fault;

  always_comb begin
    mask = width_mask(state_i.word);
    peek = state_i.word ? state_i.c[14] : state_i.c[6];
    qcomp = {state_i.c[14:0], state_i.carry} & mask;
    fl = state_i.flags;
    if (!state_i.fault) begin
      fl[FlCf] = peek;
    end
    fault = state_i.fault || (state_i.sgn && !peek);
    res_d.divide_fault = fault;
    res_d.quotient_out = 16'h0000;
    res_d.remainder_out = 16'h0000;
    if (!fault) begin
      if (state_i.sgn) begin
        res_d.remainder_out = state_i.neg_div ? ((16'h0000 - state_i.a) & mask) : state_i.a;
        res_d.quotient_out = (state_i.neg_q ^ state_i.rep) ? ((qcomp + 16'h0001) & mask)
                                                           : (~qcomp & mask);
        fl[FlCf] = 1'b0;
        fl[FlOf] = 1'b0;
      end else begin
        res_d.remainder_out = state_i.a;
        res_d.quotient_out = ~qcomp & mask;
      end
    end
    res_d.flags_after = fl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o = res_q;

endmodule
`default_nettype wire

>>> hdl/x86_div_idiv_microcode_divider.sv
// Top level of the 8086 DIV/IDIV divider: operand stage, sixteen chained
// divide cells and the result stage. Depends on xdiv_pkg and xdiv_if.
//
// Takes one divide word per cycle unless the chain holds, and returns one
// result word per divide, in order, through one operand stage, one cell per
// quotient bit (sixteen, byte divides pass the upper eight unchanged) and
// the result register. The whole chain holds while a result waits untaken,
// so in_i.ready follows out_o.ready whenever the result register is full.
`default_nettype none
module x86_div_idiv_microcode_divider import xdiv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xdiv_in_if.sink   in_i,
  xdiv_out_if.source out_o
);

  logic       en;
  logic       out_valid;
  div_res_t   res;
  logic       valid_chain [NumCells+1];
  div_state_t state_chain [NumCells+1];

  assign en = !out_valid || out_o.ready;
  assign in_i.ready = en;

  xdiv_prep u_prep (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (in_i.valid),
    .operation_i     (in_i.operation),
    .word_width_i    (in_i.word_width),
    .dividend_high_i (in_i.dividend_high),
    .dividend_low_i  (in_i.dividend_low),
    .divisor_value_i (in_i.divisor_value),
    .flags_before_i  (in_i.flags_before),
    .rep_prefix_i    (in_i.rep_prefix),
    .valid_o         (valid_chain[0]),
    .state_o         (state_chain[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    xdiv_cell #(
      .Step (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_chain[k]),
      .state_i (state_chain[k]),
      .valid_o (valid_chain[k+1]),
      .state_o (state_chain[k+1])
    );
  end

  xdiv_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_chain[NumCells]),
    .state_i (state_chain[NumCells]),
    .valid_o (out_valid),
    .res_o   (res)
  );

  assign out_o.valid = out_valid;
  assign out_o.divide_fault = res.divide_fault;
  assign out_o.quotient_out = res.quotient_out;
  assign out_o.remainder_out = res.remainder_out;
  assign out_o.flags_after = res.flags_after;

endmodule
`default_nettype wire
